// ----- rtl/core/rmp_pkg.sv -----
`default_nettype none

package rmp_pkg;

    // Fixed field widths
    localparam int COORD_W  = 10;           // x_pos, y_pos
    localparam int SRC_W    = COORD_W + 1;  // cell centre can pass the last input column
    localparam int IMG_W    = 11;           // image_width, image_height
    localparam int SIZE_W   = 13;           // region origin / extent, saturated image size
    localparam int AXIS_W   = SIZE_W + 2;   // signed room for origin + extent
    localparam int CELL_W   = 8;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;

    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Register map (word index)
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_REGION_X     = 3'd2;
    localparam logic [2:0] REG_REGION_Y     = 3'd3;
    localparam logic [2:0] REG_REGION_W     = 3'd4;
    localparam logic [2:0] REG_REGION_H     = 3'd5;
    localparam logic [2:0] REG_CELL_SIZE    = 3'd6;

    // Reset values
    localparam logic [IMG_W-1:0]         RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [IMG_W-1:0]         RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic signed [SIZE_W-1:0] RST_REGION_X     = 13'sd0;
    localparam logic signed [SIZE_W-1:0] RST_REGION_Y     = 13'sd0;
    localparam logic [SIZE_W-1:0]        RST_REGION_W     = 13'd0;
    localparam logic [SIZE_W-1:0]        RST_REGION_H     = 13'd0;
    localparam logic [CELL_W-1:0]        RST_CELL_SIZE    = 8'd8;

    typedef struct packed {
        logic                in_rgn;
        logic [SIZE_W-1:0]   stop;
        logic [COORD_W-1:0]  off;
    } t_axis;

endpackage

`default_nettype wire

// ----- rtl/core/region_mosaic_pixelate.sv -----
// Channel   | Direction | Handshake                        | Payload
// ----------+-----------+----------------------------------+------------------------------------
// request   | in        | i_in_valid / o_in_ready          | req_type, x_pos, y_pos, BGR
// result    | out       | o_out_valid / i_out_ready        | BGR, in_mosaic (reads only)
// config    | in        | psel, penable, pwrite, pready=1  | paddr, pwdata, prdata
//
// A write request is stored at the edge it is accepted.
// A read request goes through bounds setup, 10 bit-serial remainder steps (offset mod
// cell_size, both axes side by side), centre, frame store read and output load; no new
// request is taken until it has returned to idle.
// Reset restores the register defaults; the frame store is not cleared.
// The output register holds a waiting result; requests are still taken meanwhile, and a
// further read waits in its last step until that register is free.

`default_nettype none

module region_mosaic_pixelate
    import rmp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,

    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire                  i_req_type,
    input  wire  [COORD_W-1:0]   i_x_pos,
    input  wire  [COORD_W-1:0]   i_y_pos,
    input  wire  [CHAN_W-1:0]    i_in_blue,
    input  wire  [CHAN_W-1:0]    i_in_green,
    input  wire  [CHAN_W-1:0]    i_in_red,

    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [CHAN_W-1:0]    o_out_blue,
    output logic [CHAN_W-1:0]    o_out_green,
    output logic [CHAN_W-1:0]    o_out_red,
    output logic                 o_in_mosaic,

    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [APB_AW-1:0]    paddr,
    input  wire  [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = $clog2(DEPTH);
    localparam int DIV_STEPS = COORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_CENTER = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;
    localparam logic [2:0] S_DATA   = 3'd5;

    // Configuration
    logic [IMG_W-1:0]         r_image_width;
    logic [IMG_W-1:0]         r_image_height;
    logic signed [SIZE_W-1:0] r_region_x;
    logic signed [SIZE_W-1:0] r_region_y;
    logic [SIZE_W-1:0]        r_region_w;
    logic [SIZE_W-1:0]        r_region_h;
    logic [CELL_W-1:0]        r_cell_size;

    // Control
    logic [2:0]               r_state;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_out_valid;

    // Datapath
    logic [COORD_W-1:0]       r_x;
    logic [COORD_W-1:0]       r_y;
    logic                     r_in_store;
    logic                     r_mosaic;
    logic [COORD_W-1:0]       r_off_x;
    logic [COORD_W-1:0]       r_off_y;
    logic [SIZE_W-1:0]        r_stop_x;
    logic [SIZE_W-1:0]        r_stop_y;
    logic [CELL_W-1:0]        r_rem_x;
    logic [CELL_W-1:0]        r_rem_y;
    logic [SRC_W-1:0]         r_src_x;
    logic [SRC_W-1:0]         r_src_y;
    logic [PIX_W-1:0]         r_rd_data;
    logic [CHAN_W-1:0]        r_out_blue;
    logic [CHAN_W-1:0]        r_out_green;
    logic [CHAN_W-1:0]        r_out_red;
    logic                     r_in_mosaic;

    logic [PIX_W-1:0]         mem [DEPTH];

    logic                     in_acc;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;
    logic                     in_store;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic [SIZE_W-1:0]        img_w;
    logic [SIZE_W-1:0]        img_h;
    t_axis                    ax;
    t_axis                    ay;
    logic                     out_load;

    function automatic t_axis f_axis(
        input logic [COORD_W-1:0]        p,
        input logic signed [SIZE_W-1:0]  org,
        input logic [SIZE_W-1:0]         len,
        input logic [SIZE_W-1:0]         img
    );
        logic signed [AXIS_W-1:0] org_e;
        logic signed [AXIS_W-1:0] end_raw;
        logic signed [AXIS_W-1:0] end_c;
        logic signed [AXIS_W-1:0] img_e;
        logic signed [AXIS_W-1:0] start_e;
        logic signed [AXIS_W-1:0] p_e;
        logic signed [AXIS_W-1:0] diff;
        t_axis                    r;
        org_e   = AXIS_W'(org);
        img_e   = $signed({2'b00, img});
        end_raw = org_e + $signed({2'b00, len});
        // end uses the unclamped origin, start the clamped one
        end_c   = (end_raw > img_e) ? img_e : end_raw;
        start_e = (org_e < 0) ? '0 : org_e;
        p_e     = $signed({5'b00000, p});
        diff    = p_e - start_e;
        r.in_rgn = (p_e >= start_e) && (p_e < end_c);
        r.stop   = end_c[SIZE_W-1:0];
        r.off    = diff[COORD_W-1:0];
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] f_div_step(
        input logic [CELL_W-1:0] rem,
        input logic              b,
        input logic [CELL_W-1:0] cs
    );
        logic [CELL_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, cs}) begin
            t = t - {1'b0, cs};
        end
        return t[CELL_W-1:0];
    endfunction

    // Cell start is p minus its offset remainder; end clipped to the region end.
    function automatic logic [SRC_W-1:0] f_src(
        input logic [COORD_W-1:0] p,
        input logic [CELL_W-1:0]  rem,
        input logic [CELL_W-1:0]  cs,
        input logic [SIZE_W-1:0]  stop
    );
        logic [COORD_W-1:0] c0;
        logic [COORD_W:0]   c1s;
        logic [SIZE_W-1:0]  c1;
        logic [SIZE_W:0]    sum;
        c0  = p - {2'b00, rem};
        c1s = {1'b0, c0} + {3'b000, cs};
        c1  = ({2'b00, c1s} > stop) ? stop : {2'b00, c1s};
        sum = {4'b0000, c0} + {1'b0, c1};
        return sum[SRC_W:1];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign cfg_idx     = paddr[APB_AW-1:2];

    assign o_out_valid = r_out_valid;
    assign o_out_blue  = r_out_blue;
    assign o_out_green = r_out_green;
    assign o_out_red   = r_out_red;
    assign o_in_mosaic = r_in_mosaic;

    assign in_store = ({3'b000, i_x_pos} < SIZE_W'(MAX_WIDTH))
                   && ({3'b000, i_y_pos} < SIZE_W'(MAX_HEIGHT));
    assign wr_en    = in_acc && (i_req_type == REQ_WRITE) && in_store;
    assign wr_addr  = AW'(i_y_pos) * AW'(MAX_WIDTH) + AW'(i_x_pos);
    assign rd_addr  = r_in_store ? (AW'(r_src_y) * AW'(MAX_WIDTH) + AW'(r_src_x)) : '0;

    assign img_w = ({2'b00, r_image_width} > SIZE_W'(MAX_WIDTH))
                 ? SIZE_W'(MAX_WIDTH) : {2'b00, r_image_width};
    assign img_h = ({2'b00, r_image_height} > SIZE_W'(MAX_HEIGHT))
                 ? SIZE_W'(MAX_HEIGHT) : {2'b00, r_image_height};

    assign ax = f_axis(r_x, r_region_x, r_region_w, img_w);
    assign ay = f_axis(r_y, r_region_y, r_region_h, img_h);

    assign out_load = (r_state == S_DATA) && (!r_out_valid || i_out_ready);

    always_comb begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_image_height);
            REG_REGION_X:     prdata = APB_DW'($unsigned(r_region_x));
            REG_REGION_Y:     prdata = APB_DW'($unsigned(r_region_y));
            REG_REGION_W:     prdata = APB_DW'(r_region_w);
            REG_REGION_H:     prdata = APB_DW'(r_region_h);
            REG_CELL_SIZE:    prdata = APB_DW'(r_cell_size);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_region_x     <= RST_REGION_X;
            r_region_y     <= RST_REGION_Y;
            r_region_w     <= RST_REGION_W;
            r_region_h     <= RST_REGION_H;
            r_cell_size    <= RST_CELL_SIZE;
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_IMAGE_WIDTH:  r_image_width  <= pwdata[IMG_W-1:0];
                    REG_IMAGE_HEIGHT: r_image_height <= pwdata[IMG_W-1:0];
                    REG_REGION_X:     r_region_x     <= $signed(pwdata[SIZE_W-1:0]);
                    REG_REGION_Y:     r_region_y     <= $signed(pwdata[SIZE_W-1:0]);
                    REG_REGION_W:     r_region_w     <= pwdata[SIZE_W-1:0];
                    REG_REGION_H:     r_region_h     <= pwdata[SIZE_W-1:0];
                    REG_CELL_SIZE:    r_cell_size    <= pwdata[CELL_W-1:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_req_type == REQ_READ)) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= S_DIV;
                    r_cnt   <= CNT_W'(DIV_STEPS - 1);
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_CENTER;
                    end
                end
                S_CENTER: r_state <= S_READ;
                S_READ:   r_state <= S_DATA;
                S_DATA: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_x        <= i_x_pos;
                    r_y        <= i_y_pos;
                    r_in_store <= in_store;
                end
            end
            S_SETUP: begin
                r_mosaic <= (r_cell_size != '0) && ax.in_rgn && ay.in_rgn && r_in_store;
                r_off_x  <= ax.off;
                r_off_y  <= ay.off;
                r_stop_x <= ax.stop;
                r_stop_y <= ay.stop;
                r_rem_x  <= '0;
                r_rem_y  <= '0;
            end
            S_DIV: begin
                // restoring remainder, one offset bit per cycle, MSB first
                r_rem_x <= f_div_step(r_rem_x, r_off_x[COORD_W-1], r_cell_size);
                r_rem_y <= f_div_step(r_rem_y, r_off_y[COORD_W-1], r_cell_size);
                r_off_x <= r_off_x << 1;
                r_off_y <= r_off_y << 1;
            end
            S_CENTER: begin
                r_src_x <= r_mosaic ? f_src(r_x, r_rem_x, r_cell_size, r_stop_x)
                                    : {1'b0, r_x};
                r_src_y <= r_mosaic ? f_src(r_y, r_rem_y, r_cell_size, r_stop_y)
                                    : {1'b0, r_y};
            end
            S_DATA: begin
                if (out_load) begin
                    r_out_blue  <= r_in_store ? r_rd_data[CHAN_W-1:0]          : '0;
                    r_out_green <= r_in_store ? r_rd_data[2*CHAN_W-1:CHAN_W]   : '0;
                    r_out_red   <= r_in_store ? r_rd_data[PIX_W-1:2*CHAN_W]    : '0;
                    r_in_mosaic <= r_mosaic;
                end
            end
            default: ;
        endcase
    end

    // Frame store. A write lands at acceptance, long before any later read is issued.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= {i_in_red, i_in_green, i_in_blue};
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req_type == REQ_READ)) |=> (r_state == S_SETUP))
        else $error("read request did not start the bounds setup");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |=> (r_state == S_DIV) && (r_cnt == CNT_W'(DIV_STEPS - 1)))
        else $error("remainder loop not armed for a full pass");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CENTER && r_mosaic) |-> (r_rem_x < r_cell_size)
                                          && (r_rem_y < r_cell_size))
        else $error("cell offset remainder not below cell size");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DATA))
        else $error("result raised outside the output load step");

endmodule

`default_nettype wire
